@@ design/spt_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the timer table.
`default_nettype none
package spt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 48;

    localparam logic [3:0] ACT_TICK         = 4'd0;
    localparam logic [3:0] ACT_ADD_OWNED    = 4'd1;
    localparam logic [3:0] ACT_ADD_INTERNAL = 4'd2;
    localparam logic [3:0] ACT_DEL_ONE      = 4'd3;
    localparam logic [3:0] ACT_DEL_OWNER    = 4'd4;
    localparam logic [3:0] ACT_DEL_TYPE     = 4'd5;
    localparam logic [3:0] ACT_DEL_ALL      = 4'd6;
    localparam logic [3:0] ACT_FIND         = 4'd7;
    localparam logic [3:0] ACT_WAIT         = 4'd8;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;

    localparam logic [31:0] WAIT_EMPTY   = 32'hFFFF_FFFF;
    localparam logic [31:0] WAIT_TOO_BIG = 32'hFFFF_FFFE;
    localparam logic [47:0] WAIT_LIMIT   = 48'd2147483647;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_PEND,
        EMIT_IDLE,
        EMIT_REPLY
    } emit_t;

    typedef struct packed {
        logic  take_in;
        logic  tick_now;
        logic  idx_clr;
        logic  idx_inc;
        logic  rem_idx;
        logic  set_any;
        logic  clr_any;
        logic  pick_free;
        logic  ins_new;
        logic  take_head;
        logic  ins_rearm;
        emit_t emit;
        logic  emit_last;
    } spt_cmd_t;

    typedef struct packed {
        logic [3:0] act;
        logic       idx_lt_cnt;
        logic       idx_lt_cntm1;
        logic       match;
        logic       cur_le_now;
        logic       cur_le_dl;
        logic       cur_lt_dl;
        logic       can_add;
        logic       res_full;
        logic       pend_valid;
        logic       out_free;
    } spt_status_t;

endpackage
`default_nettype wire

@@ design/sorted_periodic_timer_table.sv @@
// Top level of the sorted periodic timer table.
`default_nettype none
// Holds up to sixteen periodic timers in a list kept in deadline order, with a 48-bit
// millisecond counter advanced by tick actions. One action is taken at a time and each
// answers with a run of results whose final transaction carries tlast. A tick re-inserts
// every fired timer by walking the list for its new place (up to 15 entries); deletes and
// find visit the list entry by entry; an add walks for its insertion point, after a removal
// walk when it is an owned add. The walks over the ordered slot list go one entry per
// cycle; a full output register stalls the sequence until the transaction is taken.
module sorted_periodic_timer_table
    import spt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // owner[15:0], timer_id[31:16], interval_ms[63:32], user_param[127:64]
    input  wire logic [127:0] s_axis_tdata,
    // action[3:0]
    input  wire logic [3:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // event_owner[15:0], event_id[31:16], event_param[95:32], ok[96], wait_ms[128:97]
    output logic [135:0]      m_axis_tdata,
    // kind[1:0]
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    spt_cmd_t    cmd;
    spt_status_t status;

    spt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

@@ design/spt_ctrl.sv @@
// Sequencing state machine of the timer table.
`default_nettype none
module spt_ctrl
    import spt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire spt_status_t status,
    output spt_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_T_CHECK,
        ST_T_SEARCH,
        ST_R_SCAN,
        ST_A_FREE,
        ST_A_SEARCH,
        ST_F_SCAN,
        ST_REPLY
    } state_t;

    state_t state_reg, state_next;
    logic   due;

    assign in_ready = (state_reg == ST_IDLE);
    assign due      = status.idx_lt_cnt && status.cur_le_now && !status.res_full;

    always_comb
    begin
        cmd        = '0;
        cmd.emit   = EMIT_NONE;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.idx_clr = 1'b1;
                case (status.act)
                    ACT_TICK:
                    begin
                        cmd.tick_now = 1'b1;
                        state_next   = ST_T_CHECK;
                    end
                    ACT_ADD_OWNED, ACT_DEL_ONE, ACT_DEL_OWNER, ACT_DEL_TYPE, ACT_DEL_ALL:
                        state_next = ST_R_SCAN;
                    ACT_ADD_INTERNAL: state_next = ST_A_FREE;
                    ACT_FIND:         state_next = ST_F_SCAN;
                    default:          state_next = ST_REPLY;
                endcase
            end
            ST_T_CHECK:
            begin
                if (due)
                begin
                    // A new firing tells us the held event is not the last one.
                    if (!status.pend_valid || status.out_free)
                    begin
                        cmd.take_head = 1'b1;
                        cmd.idx_clr   = 1'b1;
                        if (status.pend_valid)
                        begin
                            cmd.emit = EMIT_PEND;
                        end
                        state_next = ST_T_SEARCH;
                    end
                end
                else if (status.out_free)
                begin
                    cmd.emit      = status.pend_valid ? EMIT_PEND : EMIT_IDLE;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_T_SEARCH:
            begin
                if (status.idx_lt_cntm1 && status.cur_lt_dl)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.ins_rearm = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = ST_T_CHECK;
                end
            end
            ST_R_SCAN:
            begin
                if (status.idx_lt_cnt)
                begin
                    if (status.match)
                    begin
                        cmd.rem_idx = 1'b1;
                        cmd.set_any = 1'b1;
                        if (status.act == ACT_DEL_ONE)
                        begin
                            state_next = ST_REPLY;
                        end
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
                else
                begin
                    state_next = (status.act == ACT_ADD_OWNED) ? ST_A_FREE : ST_REPLY;
                end
            end
            ST_A_FREE:
            begin
                cmd.clr_any = 1'b1;
                cmd.idx_clr = 1'b1;
                if (status.can_add)
                begin
                    cmd.pick_free = 1'b1;
                    state_next    = ST_A_SEARCH;
                end
                else
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_A_SEARCH:
            begin
                if (status.idx_lt_cnt && status.cur_le_dl)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.ins_new = 1'b1;
                    cmd.set_any = 1'b1;
                    state_next  = ST_REPLY;
                end
            end
            ST_F_SCAN:
            begin
                if (status.idx_lt_cnt && !status.match)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.set_any = status.idx_lt_cnt;
                    state_next  = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = EMIT_REPLY;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ design/spt_datapath.sv @@
// Timer storage, deadline-ordered slot list, time counter and result register.
`default_nettype none
module spt_datapath
    import spt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [127:0] in_data,
    input  wire logic [3:0]   in_user,
    input  wire spt_cmd_t     cmd,
    output spt_status_t       status,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [135:0]      out_data,
    output logic [1:0]        out_user,
    output logic              out_last
);

    logic [TIME_W-1:0] now_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [RES_W-1:0]  nres_reg;
    logic [TIMER_SLOTS-1:0] valid_reg;

    logic [15:0]       owner_reg    [TIMER_SLOTS];
    logic [15:0]       ident_reg    [TIMER_SLOTS];
    logic [31:0]       period_reg   [TIMER_SLOTS];
    logic [63:0]       value_reg    [TIMER_SLOTS];
    logic [TIME_W-1:0] deadline_reg [TIMER_SLOTS];
    logic [SLOT_W-1:0] order_reg    [TIMER_SLOTS];

    logic [3:0]        act_reg;
    logic [15:0]       own_reg;
    logic [15:0]       id_reg;
    logic [31:0]       ms_reg;
    logic [63:0]       val_reg;
    logic [TIME_W-1:0] dl_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              any_reg;

    logic              pend_valid_reg;
    logic [15:0]       pend_owner_reg;
    logic [15:0]       pend_id_reg;
    logic [63:0]       pend_value_reg;

    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [135:0]      out_data_reg;
    logic              out_last_reg;

    logic [SLOT_W-1:0] idx_lo;
    logic [SLOT_W-1:0] cur_slot;
    logic [TIME_W-1:0] cur_dl;
    logic [TIME_W-1:0] diff;
    logic [31:0]       wait_val;
    logic [SLOT_W-1:0] free_slot;
    logic              free_found;
    logic              match;
    logic              out_free;
    logic [31:0]       interval;

    assign idx_lo   = idx_reg[SLOT_W-1:0];
    assign cur_slot = order_reg[idx_lo];
    assign cur_dl   = deadline_reg[cur_slot];
    assign diff     = cur_dl - now_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign interval = in_data[63:32];

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = TIMER_SLOTS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        case (act_reg)
            ACT_DEL_OWNER: match = (owner_reg[cur_slot] == own_reg);
            ACT_DEL_TYPE:  match = (owner_reg[cur_slot] == 16'd0)
                                   && (ident_reg[cur_slot] == id_reg);
            ACT_DEL_ALL:   match = 1'b1;
            default:       match = (owner_reg[cur_slot] == own_reg)
                                   && (ident_reg[cur_slot] == id_reg);
        endcase
    end

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            wait_val = WAIT_EMPTY;
        end
        else if (cur_dl <= now_reg)
        begin
            wait_val = 32'd0;
        end
        else if (diff > WAIT_LIMIT)
        begin
            wait_val = WAIT_TOO_BIG;
        end
        else
        begin
            wait_val = diff[31:0];
        end
    end

    always_comb
    begin
        status.act          = act_reg;
        status.idx_lt_cnt   = (idx_reg < cnt_reg);
        status.idx_lt_cntm1 = ((idx_reg + CNT_W'(1)) < cnt_reg);
        status.match        = match;
        status.cur_le_now   = (cur_dl <= now_reg);
        status.cur_le_dl    = (cur_dl <= dl_reg);
        status.cur_lt_dl    = (cur_dl < dl_reg);
        status.can_add      = free_found && (cnt_reg != CNT_W'(TIMER_SLOTS));
        status.res_full     = (nres_reg == RES_W'(MAX_RESULTS));
        status.pend_valid   = pend_valid_reg;
        status.out_free     = out_free;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ms_reset:
            begin
                now_reg        <= '0;
                cnt_reg        <= '0;
                idx_reg        <= '0;
                nres_reg       <= '0;
                valid_reg      <= '0;
                any_reg        <= 1'b0;
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b0;
            end
        end
        else
        begin
            if (cmd.tick_now)
            begin
                now_reg <= now_reg + TIME_W'(1);
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.take_in)
            begin
                nres_reg <= '0;
                any_reg  <= 1'b0;
            end
            else if (cmd.take_head)
            begin
                nres_reg <= nres_reg + RES_W'(1);
            end
            if (cmd.set_any)
            begin
                any_reg <= 1'b1;
            end
            else if (cmd.clr_any)
            begin
                any_reg <= 1'b0;
            end
            if (cmd.rem_idx)
            begin
                valid_reg[cur_slot] <= 1'b0;
                cnt_reg             <= cnt_reg - CNT_W'(1);
            end
            if (cmd.ins_new)
            begin
                valid_reg[slot_reg] <= 1'b1;
                cnt_reg             <= cnt_reg + CNT_W'(1);
            end
            if (cmd.take_head)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.emit == EMIT_PEND)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.emit != EMIT_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            act_reg <= in_user;
            own_reg <= in_data[15:0];
            id_reg  <= in_data[31:16];
            ms_reg  <= (interval == 32'd0) ? 32'd1 : interval;
            val_reg <= in_data[127:64];
        end
        if (cmd.pick_free)
        begin
            slot_reg <= free_slot;
            dl_reg   <= now_reg + TIME_W'(ms_reg);
        end
        if (cmd.take_head)
        begin
            // The fired timer leaves the head and is searched back in by its new deadline.
            slot_reg               <= cur_slot;
            dl_reg                 <= now_reg + TIME_W'(period_reg[cur_slot]);
            deadline_reg[cur_slot] <= now_reg + TIME_W'(period_reg[cur_slot]);
            pend_owner_reg         <= owner_reg[cur_slot];
            pend_id_reg            <= ident_reg[cur_slot];
            pend_value_reg         <= value_reg[cur_slot];
            for (int k = 0; k < TIMER_SLOTS - 1; k++)
            begin
                order_reg[k] <= order_reg[k + 1];
            end
        end
        if (cmd.rem_idx)
        begin
            for (int k = 0; k < TIMER_SLOTS - 1; k++)
            begin
                if (CNT_W'(k) >= idx_reg)
                begin
                    order_reg[k] <= order_reg[k + 1];
                end
            end
        end
        if (cmd.ins_new || cmd.ins_rearm)
        begin
            for (int k = 1; k < TIMER_SLOTS; k++)
            begin
                if (CNT_W'(k) > idx_reg)
                begin
                    order_reg[k] <= order_reg[k - 1];
                end
            end
            order_reg[idx_lo] <= slot_reg;
        end
        if (cmd.ins_new)
        begin
            owner_reg[slot_reg]    <= (act_reg == ACT_ADD_INTERNAL) ? 16'd0 : own_reg;
            ident_reg[slot_reg]    <= id_reg;
            period_reg[slot_reg]   <= ms_reg;
            value_reg[slot_reg]    <= val_reg;
            deadline_reg[slot_reg] <= dl_reg;
        end
        if (cmd.emit != EMIT_NONE)
        begin
            out_last_reg <= cmd.emit_last;
            case (cmd.emit)
                EMIT_PEND:
                begin
                    out_kind_reg <= KIND_EVENT;
                    out_data_reg <= {7'd0, 32'd0, 1'b0, pend_value_reg,
                                     pend_id_reg, pend_owner_reg};
                end
                EMIT_REPLY:
                begin
                    out_kind_reg <= KIND_REPLY;
                    if (act_reg == ACT_WAIT)
                    begin
                        out_data_reg <= {7'd0, wait_val, 1'b0, 64'd0, 16'd0, 16'd0};
                    end
                    else
                    begin
                        out_data_reg <= {7'd0, 32'd0, any_reg, 64'd0, 16'd0, 16'd0};
                    end
                end
                default:
                begin
                    out_kind_reg <= KIND_IDLE;
                    out_data_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

@@ verif/sorted_periodic_timer_table_tb.sv @@
// Self-checking testbench for the sorted periodic timer table, with its own model of the list.
`default_nettype none
module sorted_periodic_timer_table_tb
    import spt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 440;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] owner;
        logic [15:0] ident;
        logic [63:0] param;
        logic        ok;
        logic [31:0] wait_ms;
        logic        last;
    } timer_result_t;

    typedef struct {
        logic [3:0]  act;
        logic [15:0] owner;
        logic [15:0] ident;
        logic [31:0] period;
        logic [63:0] param;
        bit          typed;
        logic [1:0]  kind;
        logic        ok;
        logic [31:0] wait_ms;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [3:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;

    sorted_periodic_timer_table dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Timer list as the block should hold it.
    logic [47:0] now_count;
    bit          live_slot [TIMER_SLOTS];
    logic [15:0] slot_owner [TIMER_SLOTS];
    logic [15:0] slot_ident [TIMER_SLOTS];
    logic [31:0] slot_period [TIMER_SLOTS];
    logic [63:0] slot_param [TIMER_SLOTS];
    logic [47:0] slot_deadline [TIMER_SLOTS];
    int          deadline_order [TIMER_SLOTS];
    int          live_total;

    timer_result_t pending_results [$];
    int failures = 0;
    int results_taken = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void unlink_at(int pos);
        live_slot[deadline_order[pos]] = 0;
        for (int i = pos; i + 1 < live_total; i++)
            deadline_order[i] = deadline_order[i + 1];
        live_total--;
    endfunction

    function automatic bit entry_matches(int s, int mode, logic [15:0] own, logic [15:0] id);
        case (mode)
            0: return slot_owner[s] == own && slot_ident[s] == id;
            1: return slot_owner[s] == own;
            2: return slot_owner[s] == 16'd0 && slot_ident[s] == id;
            default: return 1'b1;
        endcase
    endfunction

    function automatic bit purge_matching(int mode, logic [15:0] own, logic [15:0] id,
                                          bit first_only);
        int i;
        bit any;
        i = 0;
        any = 0;
        while (i < live_total) begin
            if (entry_matches(deadline_order[i], mode, own, id)) begin
                unlink_at(i);
                any = 1;
                if (first_only)
                    break;
            end
            else
                i++;
        end
        return any;
    endfunction

    function automatic bit arm_timer(logic [15:0] own, logic [15:0] id, logic [31:0] ms,
                                     logic [63:0] val);
        int s;
        int pos;
        logic [47:0] dl;
        if (ms == 0)
            ms = 1;
        s = 0;
        while (s < TIMER_SLOTS && live_slot[s])
            s++;
        if (s >= TIMER_SLOTS || live_total >= TIMER_SLOTS)
            return 0;
        dl = now_count + 48'(ms);
        pos = 0;
        while (pos < live_total && slot_deadline[deadline_order[pos]] <= dl)
            pos++;
        live_slot[s] = 1;
        slot_owner[s] = own;
        slot_ident[s] = id;
        slot_period[s] = ms;
        slot_param[s] = val;
        slot_deadline[s] = dl;
        for (int i = live_total; i > pos; i--)
            deadline_order[i] = deadline_order[i - 1];
        deadline_order[pos] = s;
        live_total++;
        return 1;
    endfunction

    function automatic void queue_result(logic [1:0] kind, logic [15:0] own, logic [15:0] id,
                                         logic [63:0] val, logic ok, logic [31:0] w);
        timer_result_t r;
        r.kind = kind;
        r.owner = own;
        r.ident = id;
        r.param = val;
        r.ok = ok;
        r.wait_ms = w;
        r.last = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Works out the run of results for one accepted action.
    function automatic void predict_action(logic [3:0] act, logic [15:0] own, logic [15:0] id,
                                           logic [31:0] ms, logic [63:0] val);
        int fired;
        int s;
        int j;
        bit ok;
        logic [47:0] dl;
        logic [31:0] w;
        fired = 0;
        ok = 0;
        if (act == ACT_TICK) begin
            now_count = now_count + 48'd1;
            while (live_total > 0 && fired < MAX_RESULTS) begin
                s = deadline_order[0];
                if (slot_deadline[s] > now_count)
                    break;
                queue_result(KIND_EVENT, slot_owner[s], slot_ident[s], slot_param[s], 0, 0);
                fired++;
                dl = now_count + 48'(slot_period[s]);
                slot_deadline[s] = dl;
                for (j = 0; j + 1 < live_total; j++)
                    deadline_order[j] = deadline_order[j + 1];
                j = 0;
                while (j < live_total - 1 && slot_deadline[deadline_order[j]] < dl)
                    j++;
                for (int k = live_total - 1; k > j; k--)
                    deadline_order[k] = deadline_order[k - 1];
                deadline_order[j] = s;
            end
            if (fired == 0)
                queue_result(KIND_IDLE, 0, 0, 0, 0, 0);
        end
        else if (act == ACT_WAIT) begin
            if (live_total == 0)
                w = WAIT_EMPTY;
            else begin
                dl = slot_deadline[deadline_order[0]];
                if (dl <= now_count)
                    w = 0;
                else if (dl - now_count > WAIT_LIMIT)
                    w = WAIT_TOO_BIG;
                else
                    w = 32'(dl - now_count);
            end
            queue_result(KIND_REPLY, 0, 0, 0, 0, w);
        end
        else begin
            case (act)
                ACT_ADD_OWNED:
                begin
                    void'(purge_matching(0, own, id, 0));
                    ok = arm_timer(own, id, ms, val);
                end
                ACT_ADD_INTERNAL: ok = arm_timer(16'd0, id, ms, val);
                ACT_DEL_ONE:      ok = purge_matching(0, own, id, 1);
                ACT_DEL_OWNER:    ok = purge_matching(1, own, id, 0);
                ACT_DEL_TYPE:     ok = purge_matching(2, own, id, 0);
                ACT_DEL_ALL:      ok = purge_matching(3, own, id, 0);
                ACT_FIND:
                begin
                    for (int i = 0; i < live_total; i++)
                        if (entry_matches(deadline_order[i], 0, own, id))
                            ok = 1;
                end
                default: ok = 0;
            endcase
            queue_result(KIND_REPLY, 0, 0, 0, ok, 0);
        end
        pending_results[$].last = 1'b1;
    endfunction

    task automatic send_action(logic [3:0] act, logic [15:0] own, logic [15:0] id,
                               logic [31:0] ms, logic [63:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {val, ms, id, own};
        // Ready is stable between edges, so it is looked at on the falling edge.
        forever begin
            @(negedge clk);
            if (s_axis_tready)
                break;
        end
        @(posedge clk);
        predict_action(act, own, id, ms, val);
    endtask

    task automatic send_row(stim_row_t row);
        timer_result_t r;
        send_action(row.act, row.owner, row.ident, row.period, row.param);
        if (row.typed) begin
            void'(pending_results.pop_back());
            r = '{row.kind, 16'd0, 16'd0, 64'd0, row.ok, row.wait_ms, 1'b1};
            pending_results.push_back(r);
        end
    endtask

    // Result side: random stalls, and one long hold-off so that the block backs up.
    initial
    begin
        int stall;
        bit held;
        stall = 0;
        held = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!held && results_taken >= 100) begin
                held = 1;
                stall = 400;
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0) begin
                stall = pick_gap();
                m_axis_tready <= (stall == 0);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        timer_result_t want;
        timer_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            results_taken++;
            got.owner = m_axis_tdata[15:0];
            got.ident = m_axis_tdata[31:16];
            got.param = m_axis_tdata[95:32];
            got.ok = m_axis_tdata[96];
            got.wait_ms = m_axis_tdata[128:97];
            got.kind = m_axis_tuser;
            got.last = m_axis_tlast;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, kind %0d", $time, got.kind);
                failures++;
            end
            else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected kind %0d owner %h id %h param %h ok %b wait %h last %b",
                             $time, want.kind, want.owner, want.ident, want.param, want.ok,
                             want.wait_ms, want.last);
                    $display("%0t:          actual   kind %0d owner %h id %h param %h ok %b wait %h last %b",
                             $time, got.kind, got.owner, got.ident, got.param, got.ok,
                             got.wait_ms, got.last);
                    failures++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        int quiet;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    stim_row_t directed [] = '{
        '{ACT_WAIT, 16'h0, 16'h0, 32'h0, 64'h0, 1, KIND_REPLY, 0, WAIT_EMPTY},
        '{ACT_TICK, 16'h0, 16'h0, 32'h0, 64'h0, 1, KIND_IDLE, 0, 32'h0},
        '{ACT_FIND, 16'hFFFF, 16'hFFFF, 32'h0, 64'h0, 1, KIND_REPLY, 0, 32'h0},
        '{ACT_DEL_ALL, 16'h0, 16'h0, 32'h0, 64'h0, 1, KIND_REPLY, 0, 32'h0},
        '{4'd9, 16'h1, 16'h1, 32'h1, 64'h1, 1, KIND_REPLY, 0, 32'h0},
        '{4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, '1, 1, KIND_REPLY, 0, 32'h0},
        '{ACT_ADD_OWNED, 16'hFFFF, 16'hFFFF, 32'h0, 64'h7FFFFFFFFFFFFFFF, 1, KIND_REPLY, 1, 32'h0},
        '{ACT_ADD_INTERNAL, 16'hABCD, 16'h5, 32'hFFFFFFFF, 64'h8000000000000000,
          1, KIND_REPLY, 1, 32'h0},
        '{ACT_WAIT, 16'h0, 16'h0, 32'h0, 64'h0, 0, 0, 0, 0},
        '{ACT_ADD_OWNED, 16'hFFFF, 16'hFFFF, 32'h3, 64'h11, 0, 0, 0, 0},
        '{ACT_ADD_OWNED, 16'h0001, 16'h0002, 32'h3, 64'h22, 0, 0, 0, 0},
        '{ACT_ADD_INTERNAL, 16'h0, 16'h0002, 32'h3, 64'h33, 0, 0, 0, 0},
        '{ACT_FIND, 16'h0001, 16'h0002, 32'h0, 64'h0, 0, 0, 0, 0},
        '{ACT_TICK, 16'h0, 16'h0, 32'h0, 64'h0, 0, 0, 0, 0},
        '{ACT_TICK, 16'h0, 16'h0, 32'h0, 64'h0, 0, 0, 0, 0},
        '{ACT_TICK, 16'h0, 16'h0, 32'h0, 64'h0, 0, 0, 0, 0},
        '{ACT_DEL_ONE, 16'h0001, 16'h0002, 32'h0, 64'h0, 0, 0, 0, 0},
        '{ACT_ADD_OWNED, 16'h0000, 16'h0005, 32'h2, 64'h44, 0, 0, 0, 0},
        '{ACT_DEL_TYPE, 16'h0, 16'h0002, 32'h0, 64'h0, 0, 0, 0, 0},
        '{ACT_DEL_OWNER, 16'hFFFF, 16'h0, 32'h0, 64'h0, 0, 0, 0, 0},
        '{ACT_WAIT, 16'h0, 16'h0, 32'h0, 64'h0, 0, 0, 0, 0},
        '{ACT_DEL_ALL, 16'h0, 16'h0, 32'h0, 64'h0, 0, 0, 0, 0}
    };

    function automatic logic [3:0] random_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return ACT_TICK;
        if (r < 50) return ACT_ADD_OWNED;
        if (r < 60) return ACT_ADD_INTERNAL;
        if (r < 66) return ACT_DEL_ONE;
        if (r < 71) return ACT_DEL_OWNER;
        if (r < 76) return ACT_DEL_TYPE;
        if (r < 78) return ACT_DEL_ALL;
        if (r < 86) return ACT_FIND;
        if (r < 96) return ACT_WAIT;
        return 4'($urandom_range(9, 15));
    endfunction

    initial
    begin
        logic [15:0] own;
        logic [15:0] id;
        logic [31:0] ms;
        int r;
        now_count = '0;
        live_total = 0;
        foreach (live_slot[i])
            live_slot[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_row(directed[i]);
        // Fill the table past its capacity, then let all sixteen fire on one tick.
        for (int i = 0; i < TIMER_SLOTS + 1; i++)
            send_action(ACT_ADD_INTERNAL, 16'h0, 16'h7, 32'h3, {$urandom, $urandom});
        repeat (4)
            send_action(ACT_TICK, 16'h0, 16'h0, 32'h0, 64'h0);
        send_action(ACT_DEL_ALL, 16'h0, 16'h0, 32'h0, 64'h0);

        // Small pools of owners and ids keep matches and equal deadlines frequent.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            own = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 80)
                ms = $urandom_range(0, 12);
            else if (r < 90)
                ms = $urandom_range(32'h7FFFFFF0, 32'hFFFFFFFF);
            else
                ms = $urandom;
            send_action(random_action(), own, id, ms, {$urandom, $urandom});
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
